// ----- hw/rtl/gag_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and coordinate helpers for the grid address generator
// no dependencies; imported by every module of the block

package gag_pkg;

    localparam int EXT_W       = 11;
    localparam int COORD_W     = 12;
    localparam int SUM_W       = 15;
    localparam int ADDR_W      = 30;
    localparam int PROD_W      = 2 * EXT_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int FULL_W      = EXT_W + PROD_W;
    localparam int OPC_W       = 3;
    localparam int AXIS_W      = 2;
    localparam int ERR_W       = 3;
    localparam int DIM_W       = 2;
    localparam int REFLECT_W   = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int EXT_HW_MAX  = (1 << EXT_W) - 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_J     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_K     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_MODE = 3'd4;

    localparam logic [DIM_W-1:0]     DIM_3D        = 2'd3;
    localparam logic [REFLECT_W-1:0] REFLECT_NONE  = 2'd0;
    localparam logic [REFLECT_W-1:0] REFLECT_NODE  = 2'd1;
    localparam logic [REFLECT_W-1:0] REFLECT_CELL  = 2'd2;
    localparam logic [EXT_W-1:0]     EXT_RESET     = 11'd1024;

    localparam logic [AXIS_W-1:0] AXIS_I = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_J = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_K = 2'd2;

    typedef logic [EXT_W-1:0]          t_ext;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef enum logic [OPC_W-1:0] {
        OP_SET_POS   = 3'd0,
        OP_CHECK_REL = 3'd1,
        OP_ADDR_REL  = 3'd2,
        OP_SHIFT     = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_ITERATE   = 3'd5,
        OP_NONE      = 3'd6
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 3'd0,
        ERR_NOT_SET = 3'd1,
        ERR_BAD_POS = 3'd2,
        ERR_RANGE   = 3'd3,
        ERR_JUMP    = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        BK_EXEC = 2'd0,
        BK_MUL1 = 2'd1,
        BK_MUL2 = 2'd2
    } t_back_state;

    typedef struct packed {
        t_op                 op;
        t_coord              coord_i;
        t_coord              coord_j;
        t_coord              coord_k;
        logic [AXIS_W-1:0]   axis;
        t_coord              step;
        logic [COORD_W-1:0]  step_mag;
    } t_cmd;

    typedef struct packed {
        logic                  three;
        t_ext                  ext_i;
        t_ext                  ext_j;
        t_ext                  ext_k;
        logic [REFLECT_W-1:0]  reflect;
    } t_cfg;

    function automatic logic in_range(input t_sum p, input t_ext e);
        return (p >= 0) && (p < t_sum'(e));
    endfunction

    // reflect a coordinate about the edge node or edge cell in those modes; otherwise it passes unchanged
    function automatic t_sum mirror_coord(input t_sum p, input t_ext e,
                                          input logic [REFLECT_W-1:0] mode);
        t_sum q;
        t_sum em1;
        t_sum off;
        q   = p;
        em1 = t_sum'(e) - t_sum'(1);
        off = (mode == REFLECT_CELL) ? t_sum'(1) : t_sum'(0);
        if (mode == REFLECT_NODE || mode == REFLECT_CELL) begin
            if (q < 0) begin
                q = -q - off;
            end
            if (q > em1) begin
                q = (em1 <<< 1) - q + off;
            end
        end
        return q;
    endfunction

endpackage

// ----- hw/rtl/gag_front.sv -----
`timescale 1ns / 1ps
// input stage: takes items, decodes the opcode, folds the axis and the jump size
// depends on gag_pkg

module gag_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_three,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gag_pkg::OPC_W-1:0]     i_opcode,
    input  gag_pkg::t_coord               i_coord_i,
    input  gag_pkg::t_coord               i_coord_j,
    input  gag_pkg::t_coord               i_coord_k,
    input  logic [gag_pkg::AXIS_W-1:0]    i_axis,
    input  gag_pkg::t_coord               i_step,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output gag_pkg::t_cmd                 o_cmd
);
    import gag_pkg::*;

    logic                 r_valid;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    logic                 accept;
    logic                 push;
    logic [COORD_W-1:0]   step_u;

    assign push       = r_valid && i_cmd_ready;
    assign o_in_stall = r_valid && !i_cmd_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign step_u     = i_step;

    always_comb begin
        n_cmd         = '0;
        n_cmd.coord_i = i_coord_i;
        n_cmd.coord_j = i_coord_j;
        n_cmd.coord_k = i_coord_k;
        n_cmd.step    = i_step;
        n_cmd.step_mag = step_u[COORD_W-1] ? (COORD_W'(0) - step_u) : step_u;
        if (i_opcode <= OP_ITERATE) begin
            n_cmd.op = t_op'(i_opcode);
        end else begin
            n_cmd.op = OP_NONE;
        end
        // axis taken modulo the number of axes in use
        if (i_three) begin
            n_cmd.axis = (i_axis > AXIS_K) ? AXIS_I : i_axis;
        end else begin
            n_cmd.axis = {1'b0, i_axis[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- hw/rtl/gag_queue.sv -----
`timescale 1ns / 1ps
// short command queue between the decode stage and the execution unit
// depends on gag_pkg

module gag_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  gag_pkg::t_cmd   i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output gag_pkg::t_cmd   o_pop_cmd
);
    import gag_pkg::*;

    t_cmd                 r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;
    logic                 push;
    logic                 pop;

    assign o_push_ready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- hw/rtl/gag_back.sv -----
`timescale 1ns / 1ps
// execution unit: grid position and shift state, reflection, range checks,
// two-step address multiply and the result register; depends on gag_pkg

module gag_back #(
    parameter int POS_W = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gag_pkg::t_cfg                i_cfg,
    input  logic                         i_q_valid,
    input  gag_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gag_pkg::ADDR_W-1:0]   o_address,
    output logic                         o_check_ok,
    output logic [gag_pkg::ERR_W-1:0]    o_error_code
);
    import gag_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [POS_W-1:0] r_pos_i;
    logic [POS_W-1:0] r_pos_j;
    logic [POS_W-1:0] r_pos_k;
    logic             r_pos_valid;
    t_coord           r_shift_i;
    t_coord           r_shift_j;
    t_coord           r_shift_k;

    t_ext             r_ti;
    t_ext             r_tj;
    t_ext             r_tk;
    logic             r_addr_en;
    logic             r_ok;
    t_err             r_err;
    logic [ACC_W-1:0] r_acc;
    logic [PROD_W-1:0] r_eji;

    logic             r_out_valid;
    logic [ADDR_W-1:0] r_address;
    logic             r_check_ok;
    t_err             r_error_code;

    t_cmd             cmd;
    logic             exec_en;
    logic             mul_en;
    logic             out_load;
    logic             out_free;

    t_sum pos_i_s, pos_j_s, pos_k_s;
    t_sum ei_s, ej_s, ek_s;
    t_sum it_next_i, it_wrapped_i, it_j1, it_k1;
    logic it_bad, it_wrap_i, it_wrap_j, it_wrap_k;
    logic [POS_W-1:0] it_pos_i, it_pos_j, it_pos_k;
    t_coord sh_n_i, sh_n_j, sh_n_k;
    t_sum base_i, base_j, base_k;
    t_sum off_i, off_j, off_k;
    t_sum sum_i, sum_j, sum_k;
    t_sum tgt_i, tgt_j, tgt_k;
    logic raw_ok, loc_ok;
    logic res_ok, res_addr_en;
    t_err res_err;

    logic [ACC_W-1:0]  n_acc;
    logic [PROD_W-1:0] n_eji;
    logic [FULL_W-1:0] prod_k;
    logic [FULL_W-1:0] addr_full;

    assign cmd = i_q_cmd;

    // ---------------- execute: state update and target coordinates
    assign pos_i_s = t_sum'(r_pos_i);
    assign pos_j_s = t_sum'(r_pos_j);
    assign pos_k_s = t_sum'(r_pos_k);
    assign ei_s    = t_sum'(i_cfg.ext_i);
    assign ej_s    = t_sum'(i_cfg.ext_j);
    assign ek_s    = t_sum'(i_cfg.ext_k);

    // raster advance: carry from i into j, and from j into k in 3D
    assign it_next_i    = pos_i_s + t_sum'(cmd.step);
    assign it_bad       = (cmd.step_mag >= {1'b0, i_cfg.ext_i}) || (it_next_i < 0);
    assign it_wrap_i    = (it_next_i >= ei_s);
    assign it_wrapped_i = it_wrap_i ? (it_next_i - ei_s) : it_next_i;
    assign it_j1        = pos_j_s + t_sum'(1);
    assign it_k1        = pos_k_s + t_sum'(1);
    assign it_wrap_j    = (it_j1 >= ej_s);
    assign it_wrap_k    = (it_k1 >= ek_s);
    assign it_pos_i     = it_wrapped_i[POS_W-1:0];
    assign it_pos_j     = !it_wrap_i ? r_pos_j : (it_wrap_j ? '0 : it_j1[POS_W-1:0]);
    assign it_pos_k     = (it_wrap_i && it_wrap_j && i_cfg.three)
                        ? (it_wrap_k ? '0 : it_k1[POS_W-1:0]) : r_pos_k;

    assign sh_n_i = (cmd.axis == AXIS_I) ? cmd.step : r_shift_i;
    assign sh_n_j = (cmd.axis == AXIS_J) ? cmd.step : r_shift_j;
    assign sh_n_k = (cmd.axis == AXIS_K) ? cmd.step : r_shift_k;

    always_comb begin
        base_i = pos_i_s;
        base_j = pos_j_s;
        base_k = pos_k_s;
        off_i  = t_sum'(cmd.coord_i);
        off_j  = t_sum'(cmd.coord_j);
        off_k  = t_sum'(cmd.coord_k);
        unique case (cmd.op)
            OP_SET_POS: begin
                base_i = '0;
                base_j = '0;
                base_k = '0;
            end
            OP_SHIFT: begin
                off_i = t_sum'(sh_n_i);
                off_j = t_sum'(sh_n_j);
                off_k = t_sum'(sh_n_k);
            end
            OP_ITERATE: begin
                base_i = t_sum'(it_pos_i);
                base_j = t_sum'(it_pos_j);
                base_k = t_sum'(it_pos_k);
                off_i  = '0;
                off_j  = '0;
                off_k  = '0;
            end
            default: begin
            end
        endcase
    end

    assign sum_i = base_i + off_i;
    assign sum_j = base_j + off_j;
    assign sum_k = base_k + off_k;

    assign raw_ok = in_range(sum_i, i_cfg.ext_i) && in_range(sum_j, i_cfg.ext_j)
                 && (!i_cfg.three || in_range(sum_k, i_cfg.ext_k));

    assign tgt_i = mirror_coord(sum_i, i_cfg.ext_i, i_cfg.reflect);
    assign tgt_j = mirror_coord(sum_j, i_cfg.ext_j, i_cfg.reflect);
    assign tgt_k = mirror_coord(sum_k, i_cfg.ext_k, i_cfg.reflect);

    assign loc_ok = in_range(tgt_i, i_cfg.ext_i) && in_range(tgt_j, i_cfg.ext_j)
                 && (!i_cfg.three || in_range(tgt_k, i_cfg.ext_k));

    always_comb begin
        res_ok      = 1'b0;
        res_err     = ERR_OK;
        res_addr_en = 1'b0;
        unique case (cmd.op) inside
            OP_SET_POS: begin
                res_ok      = raw_ok;
                res_err     = raw_ok ? ERR_OK : ERR_BAD_POS;
                res_addr_en = raw_ok;
            end
            OP_CHECK_REL: begin
                res_ok = raw_ok;
            end
            OP_ADDR_REL, OP_SHIFT: begin
                if (!r_pos_valid) begin
                    res_err = ERR_NOT_SET;
                end else begin
                    res_err     = loc_ok ? ERR_OK : ERR_RANGE;
                    res_addr_en = loc_ok;
                end
            end
            OP_ITERATE: begin
                if (it_bad) begin
                    res_err = ERR_JUMP;
                end else if (!r_pos_valid) begin
                    res_err = ERR_NOT_SET;
                end else begin
                    res_err     = loc_ok ? ERR_OK : ERR_RANGE;
                    res_addr_en = loc_ok;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_i     <= '0;
            r_pos_j     <= '0;
            r_pos_k     <= '0;
            r_pos_valid <= 1'b0;
            r_shift_i   <= '0;
            r_shift_j   <= '0;
            r_shift_k   <= '0;
        end else if (exec_en) begin
            case (cmd.op)
                OP_SET_POS: begin
                    // in-range axes are written even when another axis fails
                    if (in_range(sum_i, i_cfg.ext_i)) begin
                        r_pos_i <= sum_i[POS_W-1:0];
                    end
                    if (in_range(sum_j, i_cfg.ext_j)) begin
                        r_pos_j <= sum_j[POS_W-1:0];
                    end
                    if (i_cfg.three && in_range(sum_k, i_cfg.ext_k)) begin
                        r_pos_k <= sum_k[POS_W-1:0];
                    end
                    r_pos_valid <= raw_ok;
                end
                OP_CHECK_REL: begin
                    r_pos_valid <= raw_ok;
                end
                OP_SHIFT: begin
                    if (r_pos_valid) begin
                        r_shift_i <= sh_n_i;
                        r_shift_j <= sh_n_j;
                        r_shift_k <= sh_n_k;
                    end
                end
                OP_CLEAR: begin
                    r_shift_i <= '0;
                    r_shift_j <= '0;
                    r_shift_k <= '0;
                end
                OP_ITERATE: begin
                    if (!it_bad && r_pos_valid) begin
                        r_pos_i <= it_pos_i;
                        r_pos_j <= it_pos_j;
                        r_pos_k <= it_pos_k;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_ti      <= tgt_i[EXT_W-1:0];
            r_tj      <= tgt_j[EXT_W-1:0];
            r_tk      <= tgt_k[EXT_W-1:0];
            r_addr_en <= res_addr_en;
            r_ok      <= res_ok;
            r_err     <= res_err;
        end
    end

    // ---------------- address: i + j*Ei, then + k*(Ej*Ei) in 3D
    assign n_acc     = ACC_W'(r_ti) + ACC_W'(PROD_W'(r_tj) * PROD_W'(i_cfg.ext_i));
    assign n_eji     = PROD_W'(i_cfg.ext_j) * PROD_W'(i_cfg.ext_i);
    assign prod_k    = FULL_W'(r_tk) * FULL_W'(r_eji);
    assign addr_full = FULL_W'(r_acc) + (i_cfg.three ? prod_k : '0);

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_acc <= n_acc;
            r_eji <= n_eji;
        end
    end

    // ---------------- sequencer
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_EXEC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_EXEC: begin
                if (i_q_valid) begin
                    n_state = BK_MUL1;
                end
            end
            BK_MUL1: begin
                n_state = BK_MUL2;
            end
            BK_MUL2: begin
                if (out_free) begin
                    n_state = BK_EXEC;
                end
            end
            default: begin
                n_state = BK_EXEC;
            end
        endcase
    end

    always_comb begin
        exec_en  = 1'b0;
        mul_en   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BK_EXEC: begin
                exec_en = i_q_valid;
            end
            BK_MUL1: begin
                mul_en = 1'b1;
            end
            BK_MUL2: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop = exec_en;

    // ---------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_address    <= r_addr_en ? addr_full[ADDR_W-1:0] : '0;
            r_check_ok   <= r_ok;
            r_error_code <= r_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_address    = r_address;
    assign o_check_ok   = r_check_ok;
    assign o_error_code = r_error_code;

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error_code != ERR_OK) |-> (r_address == '0))
        else $error("nonzero address on an error result");

    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_check_ok) |-> (r_error_code == ERR_OK))
        else $error("check_ok set together with an error code");

    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_pos_valid) |->
            $past(exec_en && (cmd.op == OP_SET_POS || cmd.op == OP_CHECK_REL)))
        else $error("position valid cleared outside set or check");

    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_shift_i) |->
            $past(exec_en && (cmd.op == OP_SHIFT || cmd.op == OP_CLEAR)))
        else $error("shift changed outside shift or clear");

endmodule

// ----- hw/rtl/grid_address_generator.sv -----
`timescale 1ns / 1ps
// top level of the grid address generator: configuration registers, decode stage,
// command queue and execution unit; depends on gag_pkg, gag_front, gag_queue, gag_back
//
//  channel   handshake                 payload
//  cfg       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//  in        i_in_valid / o_in_stall   i_opcode, i_coord_i/j/k, i_axis, i_step
//  out       o_out_valid / i_out_stall o_address, o_check_ok, o_error_code
//
//  every item passes through the execute, first multiply and second multiply states
//  of the execution unit, which takes no new item until the current one leaves the
//  second multiply state; a stalled output holds it there
//  the decode stage and a 2-entry queue keep taking items while a result waits
//  synchronous active-low reset; clears position, shifts and valid flag, and sets config defaults
//  configuration writes are taken every cycle (o_cfg_ready is held high)

module grid_address_generator #(
    parameter int MAX_EXTENT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gag_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gag_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [gag_pkg::OPC_W-1:0]         i_opcode,
    input  logic signed [gag_pkg::COORD_W-1:0] i_coord_i,
    input  logic signed [gag_pkg::COORD_W-1:0] i_coord_j,
    input  logic signed [gag_pkg::COORD_W-1:0] i_coord_k,
    input  logic [gag_pkg::AXIS_W-1:0]        i_axis,
    input  logic signed [gag_pkg::COORD_W-1:0] i_step,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gag_pkg::ADDR_W-1:0]        o_address,
    output logic                              o_check_ok,
    output logic [gag_pkg::ERR_W-1:0]         o_error_code
);
    import gag_pkg::*;

    localparam int   POS_W     = $clog2(MAX_EXTENT);
    localparam int   EXT_LIMIT = (MAX_EXTENT > EXT_HW_MAX) ? EXT_HW_MAX : MAX_EXTENT;
    localparam t_ext EXT_CLAMP = EXT_W'(EXT_LIMIT);

    logic [DIM_W-1:0]     r_dimensions;
    t_ext                 r_extent_i;
    t_ext                 r_extent_j;
    t_ext                 r_extent_k;
    logic [REFLECT_W-1:0] r_reflect_mode;
    logic                 cfg_wr;
    t_cfg                 cfg;

    logic                 cmd_valid;
    logic                 cmd_ready;
    t_cmd                 cmd;
    logic                 q_valid;
    logic                 q_pop;
    t_cmd                 q_cmd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimensions   <= DIM_3D;
            r_extent_i     <= EXT_RESET;
            r_extent_j     <= EXT_RESET;
            r_extent_k     <= EXT_RESET;
            r_reflect_mode <= REFLECT_NONE;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_DIMENSIONS:   r_dimensions   <= i_cfg_data[DIM_W-1:0];
                CFG_EXTENT_I:     r_extent_i     <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_J:     r_extent_j     <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_K:     r_extent_k     <= i_cfg_data[EXT_W-1:0];
                CFG_REFLECT_MODE: r_reflect_mode <= i_cfg_data[REFLECT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // extents above the supported maximum act as the maximum
    assign cfg.three   = (r_dimensions == DIM_3D);
    assign cfg.ext_i   = (r_extent_i > EXT_CLAMP) ? EXT_CLAMP : r_extent_i;
    assign cfg.ext_j   = (r_extent_j > EXT_CLAMP) ? EXT_CLAMP : r_extent_j;
    assign cfg.ext_k   = (r_extent_k > EXT_CLAMP) ? EXT_CLAMP : r_extent_k;
    assign cfg.reflect = r_reflect_mode;

    gag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_three     (cfg.three),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_coord_i   (i_coord_i),
        .i_coord_j   (i_coord_j),
        .i_coord_k   (i_coord_k),
        .i_axis      (i_axis),
        .i_step      (i_step),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    gag_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid),
        .o_push_ready (cmd_ready),
        .i_push_cmd   (cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_cmd    (q_cmd)
    );

    gag_back #(
        .POS_W (POS_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_address    (o_address),
        .o_check_ok   (o_check_ok),
        .o_error_code (o_error_code)
    );

endmodule

// ----- bench/grid_address_generator_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for grid_address_generator: queue-fed driver, checking monitor
// and an in-bench model of position, shifts and configuration; depends on gag_pkg

module grid_address_generator_tb;
    import gag_pkg::*;

    localparam int GRID_MAX_EXTENT = 1024;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_CYCLES     = 150;
    localparam logic [OPC_W-1:0]     OP_UNUSED_HI  = 3'd7;
    localparam logic [DIM_W-1:0]     DIM_2D        = 2'd2;
    localparam logic [REFLECT_W-1:0] REFLECT_RSVD  = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]  opc;
        t_coord            ci;
        t_coord            cj;
        t_coord            ck;
        logic [AXIS_W-1:0] axis;
        t_coord            step;
    } t_grid_op;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              check_ok;
        logic [ERR_W-1:0]  error_code;
    } t_grid_access;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OPC_W-1:0]      i_opcode = '0;
    t_coord                i_coord_i = '0;
    t_coord                i_coord_j = '0;
    t_coord                i_coord_k = '0;
    logic [AXIS_W-1:0]     i_axis = '0;
    t_coord                i_step = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ADDR_W-1:0]     o_address;
    logic                  o_check_ok;
    logic [ERR_W-1:0]      o_error_code;

    grid_address_generator #(.MAX_EXTENT(GRID_MAX_EXTENT)) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state, reset values
    logic [DIM_W-1:0]     cfg_dims = DIM_3D;
    t_ext                 cfg_ext_i = EXT_RESET;
    t_ext                 cfg_ext_j = EXT_RESET;
    t_ext                 cfg_ext_k = EXT_RESET;
    logic [REFLECT_W-1:0] cfg_reflect = REFLECT_NONE;
    int pos_i = 0, pos_j = 0, pos_k = 0;
    bit pos_valid = 1'b0;
    int shift_i = 0, shift_j = 0, shift_k = 0;

    t_grid_op     queued_ops[$];
    t_grid_access expected_access[$];
    t_grid_op     offered_op;
    int send_gap = 0, send_calm = 0, stall_left = 0, recv_calm = 0, hold_left = 0;
    int items_sent = 0, results_checked = 0, fail_count = 0, cycle_count = 0;
    int config_count = 0;
    int err_hist[5] = '{default: 0};

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int eff_extent(t_ext r);
        return (int'(r) > GRID_MAX_EXTENT) ? GRID_MAX_EXTENT : int'(r);
    endfunction

    function automatic bit on_grid(int p, int e);
        return (p >= 0) && (p < e);
    endfunction

    function automatic int reflect_coord(int p, int e);
        int off;
        if (cfg_reflect == REFLECT_NODE) off = 0;
        else if (cfg_reflect == REFLECT_CELL) off = 1;
        else return p;
        if (p < 0) p = -p - off;
        if (p > e - 1) p = 2 * (e - 1) - p + off;
        return p;
    endfunction

    // linear address of the position moved by an offset, 0 when off the grid
    function automatic bit locate_address(int ri, int rj, int rk,
                                          output logic [ADDR_W-1:0] adr);
        int ei, ej, ek, pi, pj, pk;
        longint lin;
        adr = '0;
        ei  = eff_extent(cfg_ext_i);
        ej  = eff_extent(cfg_ext_j);
        ek  = eff_extent(cfg_ext_k);
        pi  = reflect_coord(pos_i + ri, ei);
        pj  = reflect_coord(pos_j + rj, ej);
        pk  = reflect_coord(pos_k + rk, ek);
        if (!on_grid(pi, ei) || !on_grid(pj, ej)) return 1'b0;
        lin = longint'(pi) + longint'(pj) * longint'(ei);
        if (cfg_dims == DIM_3D) begin
            if (!on_grid(pk, ek)) return 1'b0;
            lin += longint'(pk) * longint'(ej) * longint'(ei);
        end
        adr = lin[ADDR_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_grid_access compute_grid_access(t_grid_op g);
        t_grid_access      r;
        logic [ADDR_W-1:0] adr;
        logic [AXIS_W-1:0] sel;
        int ci, cj, ck, st, ei, ej, ek, ni, nj, nk, mag;
        bit three, good;
        r     = '0;
        ci    = int'(g.ci);
        cj    = int'(g.cj);
        ck    = int'(g.ck);
        st    = int'(g.step);
        ei    = eff_extent(cfg_ext_i);
        ej    = eff_extent(cfg_ext_j);
        ek    = eff_extent(cfg_ext_k);
        three = (cfg_dims == DIM_3D);
        case (g.opc)
            OP_SET_POS: begin
                // in-range axes are written even when another axis fails
                good = 1'b1;
                if (on_grid(ci, ei)) pos_i = ci; else good = 1'b0;
                if (on_grid(cj, ej)) pos_j = cj; else good = 1'b0;
                if (three) begin
                    if (on_grid(ck, ek)) pos_k = ck; else good = 1'b0;
                end
                pos_valid  = good;
                r.check_ok = good;
                if (!good) r.error_code = ERR_BAD_POS;
                else if (!locate_address(0, 0, 0, adr)) r.error_code = ERR_RANGE;
                else r.address = adr;
            end
            OP_CHECK_REL: begin
                good = on_grid(pos_i + ci, ei) && on_grid(pos_j + cj, ej);
                if (three && !on_grid(pos_k + ck, ek)) good = 1'b0;
                pos_valid  = good;
                r.check_ok = good;
            end
            OP_ADDR_REL: begin
                if (!pos_valid) r.error_code = ERR_NOT_SET;
                else if (!locate_address(ci, cj, ck, adr)) r.error_code = ERR_RANGE;
                else r.address = adr;
            end
            OP_SHIFT: begin
                if (!pos_valid) begin
                    r.error_code = ERR_NOT_SET;
                end else begin
                    sel = AXIS_W'(int'(g.axis) % (three ? 3 : 2));
                    case (sel)
                        AXIS_I:  shift_i = st;
                        AXIS_J:  shift_j = st;
                        default: shift_k = st;
                    endcase
                    // the new shift stays even when the address is off the grid
                    if (!locate_address(shift_i, shift_j, shift_k, adr))
                        r.error_code = ERR_RANGE;
                    else
                        r.address = adr;
                end
            end
            OP_CLEAR: begin
                shift_i = 0;
                shift_j = 0;
                shift_k = 0;
            end
            OP_ITERATE: begin
                mag = (st < 0) ? -st : st;
                ni  = pos_i + st;
                // jump check comes before the not-set check
                if (mag >= ei || ni < 0) begin
                    r.error_code = ERR_JUMP;
                end else if (!pos_valid) begin
                    r.error_code = ERR_NOT_SET;
                end else begin
                    if (ni >= ei) begin
                        nj = pos_j + 1;
                        ni -= ei;
                        if (nj >= ej) begin
                            nj = 0;
                            if (three) begin
                                nk = pos_k + 1;
                                if (nk >= ek) nk = 0;
                                pos_k = nk;
                            end
                        end
                        pos_j = nj;
                    end
                    pos_i = ni;
                    if (!locate_address(0, 0, 0, adr)) r.error_code = ERR_RANGE;
                    else r.address = adr;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_coord pick_coord(int ext, bit absolute);
        int r, lo, hi, v;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            if (absolute && ext > 0 && r < 72) begin
                v = $urandom_range(0, ext - 1);
            end else begin
                lo = absolute ? -1 : -(ext + 1);
                hi = ext + 1;
                v  = lo + int'($urandom_range(0, hi - lo));
            end
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       v = -2048;
                1:       v = 2047;
                2:       v = 0;
                default: v = -1;
            endcase
        end else begin
            v = int'($urandom_range(0, 4095)) - 2048;
        end
        return t_coord'(v);
    endfunction

    function automatic t_coord pick_jump(int ei);
        int r, v;
        r = $urandom_range(0, 99);
        if (ei > 1 && r < 70) v = $urandom_range(1, ei - 1);
        else if (ei > 1 && r < 82) v = -int'($urandom_range(1, ei - 1));
        else if (r < 90) v = (r < 86) ? ei : -ei;
        else v = int'($urandom_range(0, 4095)) - 2048;
        return t_coord'(v);
    endfunction

    function automatic t_grid_op random_grid_op();
        t_grid_op g;
        int ei, ej, ek, r;
        ei     = eff_extent(cfg_ext_i);
        ej     = eff_extent(cfg_ext_j);
        ek     = eff_extent(cfg_ext_k);
        r      = $urandom_range(0, 99);
        g.axis = AXIS_W'($urandom_range(0, 3));
        g.ci   = pick_coord(ei, r < 15);
        g.cj   = pick_coord(ej, r < 15);
        g.ck   = pick_coord(ek, r < 15);
        g.step = pick_coord(ei, 1'b0);
        if (r < 15) g.opc = OP_SET_POS;
        else if (r < 27) g.opc = OP_CHECK_REL;
        else if (r < 52) g.opc = OP_ADDR_REL;
        else if (r < 67) g.opc = OP_SHIFT;
        else if (r < 72) g.opc = OP_CLEAR;
        else if (r < 96) g.opc = OP_ITERATE;
        else if (r < 98) g.opc = OP_NONE;
        else g.opc = OP_UNUSED_HI;
        if (g.opc == OP_ITERATE) g.step = pick_jump(ei);
        return g;
    endfunction

    // driver: offers queued items, predicts each one on its transfer
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_access.push_back(compute_grid_access(offered_op));
            items_sent++;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (queued_ops.size() != 0) begin
                offered_op = queued_ops.pop_front();
                i_opcode   <= offered_op.opc;
                i_coord_i  <= offered_op.ci;
                i_coord_j  <= offered_op.cj;
                i_coord_k  <= offered_op.ck;
                i_axis     <= offered_op.axis;
                i_step     <= offered_op.step;
                i_in_valid <= 1'b1;
                send_gap   = idle_len(send_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_grid_access want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_access.size() == 0) begin
                $error("result with nothing expected: address %0d check_ok %0d error_code %0d",
                       o_address, o_check_ok, o_error_code);
                fail_count++;
            end else begin
                want = expected_access.pop_front();
                if (o_address !== want.address) begin
                    $error("address: expected %0d, actual %0d", want.address, o_address);
                    fail_count++;
                end
                if (o_check_ok !== want.check_ok) begin
                    $error("check_ok: expected %0d, actual %0d", want.check_ok, o_check_ok);
                    fail_count++;
                end
                if (o_error_code !== want.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.error_code, o_error_code);
                    fail_count++;
                end
                if (want.error_code <= ERR_JUMP) err_hist[want.error_code]++;
            end
            results_checked++;
            // long hold-off so the block backs up and stalls its input
            if (results_checked % 400 == 150) hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = idle_len(recv_calm);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DIMENSIONS:   cfg_dims    = DIM_W'(data);
            CFG_EXTENT_I:     cfg_ext_i   = EXT_W'(data);
            CFG_EXTENT_J:     cfg_ext_j   = EXT_W'(data);
            CFG_EXTENT_K:     cfg_ext_k   = EXT_W'(data);
            CFG_REFLECT_MODE: cfg_reflect = REFLECT_W'(data);
            default: ;
        endcase
    endtask

    task automatic load_config(int dims, int ei, int ej, int ek, int refl);
        write_reg(CFG_DIMENSIONS, dims);
        write_reg(CFG_EXTENT_I, ei);
        write_reg(CFG_EXTENT_J, ej);
        write_reg(CFG_EXTENT_K, ek);
        write_reg(CFG_REFLECT_MODE, refl);
        i_cfg_valid <= 1'b0;
        config_count++;
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (queued_ops.size() != 0 || i_in_valid || expected_access.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic add_op(logic [OPC_W-1:0] opc, int ci, int cj, int ck, int ax, int st);
        t_grid_op g;
        g.opc  = opc;
        g.ci   = t_coord'(ci);
        g.cj   = t_coord'(cj);
        g.ck   = t_coord'(ck);
        g.axis = AXIS_W'(ax);
        g.step = t_coord'(st);
        queued_ops.push_back(g);
    endtask

    task automatic run_phase(int dims, int ei, int ej, int ek, int refl, int count);
        load_config(dims, ei, ej, ek, refl);
        @(negedge i_clk);
        repeat (count) queued_ops.push_back(random_grid_op());
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: position not set, extremes, bad jumps, raster wrap, shifts, clear, bad opcodes
        load_config(DIM_3D, 1024, 1024, 1024, REFLECT_NONE);
        @(negedge i_clk);
        add_op(OP_ADDR_REL, 0, 0, 0, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 4);
        add_op(OP_ITERATE, 0, 0, 0, 0, 1);
        add_op(OP_ITERATE, 0, 0, 0, 0, 1024);
        add_op(OP_SET_POS, 0, 0, 0, 0, 0);
        add_op(OP_SET_POS, 1023, 1023, 1023, 0, 0);
        add_op(OP_SET_POS, -2048, 2047, 5, 0, 0);
        add_op(OP_ADDR_REL, 0, 0, 0, 0, 0);
        add_op(OP_SET_POS, 1020, 5, 7, 0, 0);
        add_op(OP_ITERATE, 0, 0, 0, 0, 3);
        add_op(OP_ITERATE, 0, 0, 0, 0, 1);
        add_op(OP_ITERATE, 0, 0, 0, 0, -1);
        add_op(OP_ITERATE, 0, 0, 0, 0, -2048);
        add_op(OP_CHECK_REL, -2048, 0, 0, 0, 0);
        add_op(OP_SET_POS, 1020, 5, 7, 0, 0);
        add_op(OP_CHECK_REL, -1020, 1018, -7, 0, 0);
        add_op(OP_ADDR_REL, 2047, -2048, 0, 0, 0);
        add_op(OP_ADDR_REL, 3, -5, 1, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 2047);
        add_op(OP_SHIFT, 0, 0, 0, 3, -1);
        add_op(OP_SHIFT, 0, 0, 0, 2, 5);
        add_op(OP_CLEAR, 0, 0, 0, 0, 0);
        add_op(OP_NONE, -1, -1, -1, 3, -1);
        add_op(OP_UNUSED_HI, -1, -1, -1, 3, -1);
        add_op(OP_SET_POS, 1023, 1023, 1023, 0, 0);
        add_op(OP_ITERATE, 0, 0, 0, 0, 1023);
        wait_idle();

        run_phase(DIM_3D, 5, 4, 3, REFLECT_NODE, 180);
        run_phase(DIM_2D, 7, 6, 9, REFLECT_CELL, 150);
        run_phase(0, 1, 1, 1, REFLECT_RSVD, 80);
        run_phase(DIM_3D, 2047, 1024, 1, REFLECT_NODE, 120);
        // zero extent on the first axis puts every position off the grid
        run_phase(1, 0, 7, 9, REFLECT_CELL, 60);
        run_phase(DIM_3D, 1024, 1024, 1024, REFLECT_CELL, 120);
        repeat (6) begin
            run_phase($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(1, 12),
                      $urandom_range(1, 12), $urandom_range(0, 3), 90);
        end

        repeat (10) @(posedge i_clk);
        if (expected_access.size() != 0) begin
            $error("%0d results never arrived", expected_access.size());
            fail_count++;
        end
        $display("%0d items sent and %0d results checked over %0d configurations",
                 items_sent, results_checked, config_count);
        $display("error codes seen: ok %0d, not set %0d, bad pos %0d, range %0d, jump %0d",
                 err_hist[ERR_OK], err_hist[ERR_NOT_SET], err_hist[ERR_BAD_POS],
                 err_hist[ERR_RANGE], err_hist[ERR_JUMP]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
